// File: sv/csv_field_splitter_assert.svh
// assertion macros shared by the csv field splitter checker
// no dependencies; included by files that carry concurrent assertions
`ifndef CSV_FIELD_SPLITTER_ASSERT_SVH
`define CSV_FIELD_SPLITTER_ASSERT_SVH

// same-cycle implication under an active-low reset
`define CFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under an active-low reset
`define CFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cfs_pkg.sv
// types and constants of the csv field splitter
// no dependencies; used by every module of the block
package cfs_pkg;

  // line break codes
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;

  // register reset values
  localparam logic [7:0] DELIMITER_RESET  = 8'd44;
  localparam logic [7:0] QUOTE_CHAR_RESET = 8'd34;

  // apb address width and data width
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // most results one byte can cause, and the count width
  localparam int unsigned MAX_RES = 5;
  localparam int unsigned CNT_W   = 3;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_DELIMITER  = 1'b0,
    REG_QUOTE_CHAR = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2
  } kind_e;

  typedef enum logic [4:0] {
    PH_ROW_START   = 5'b00001,
    PH_FIELD_START = 5'b00010,
    PH_UNQUOTED    = 5'b00100,
    PH_QUOTED      = 5'b01000,
    PH_QUOTE_SEEN  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic       last;
    kind_e      kind;
    logic [7:0] content;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [CNT_W-1:0]   cnt;
    res_t [MAX_RES-1:0] res;
  } bundle_t;

endpackage

// File: sv/csv_in_if.sv
// input channel of the csv field splitter: one text byte per transaction
// no dependencies
interface csv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// File: sv/csv_out_if.sv
// output channel of the csv field splitter: one result per transaction
// no dependencies
interface csv_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] content;
  logic       last_of_run;

  modport source (output valid, output kind, output content, output last_of_run, input ready);
  modport sink   (input valid, input kind, input content, input last_of_run, output ready);
endinterface

// File: sv/cfs_front.sv
// front of the csv field splitter: parse state machine, one byte per cycle while the queue is not full
// depends on cfs_pkg; builds one result bundle per accepted byte and pushes it when it holds results
module cfs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       delimiter_i,
  input  logic [7:0]       quote_char_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_stream_i,
  input  logic             q_full_i,
  output logic             push_o,
  output cfs_pkg::bundle_t push_data_o
);

  cfs_pkg::phase_e  phase_q, phase_d;
  logic             swallow_q, swallow_d;
  cfs_pkg::bundle_t bnd;
  logic             accept;
  logic             begin_f;
  logic             is_quote, is_delim, is_break;

  // append one result to a bundle
  function automatic cfs_pkg::bundle_t add_res(cfs_pkg::bundle_t b, cfs_pkg::kind_e k,
                                               logic [7:0] c);
    cfs_pkg::bundle_t r;
    r = b;
    r.res[b.cnt] = '{last: 1'b0, kind: k, content: c};
    r.cnt = b.cnt + cfs_pkg::CNT_W'(1);
    return r;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_quote   = (data_byte_i == quote_char_i);
  assign is_delim   = (data_byte_i == delimiter_i);
  assign is_break   = (data_byte_i == cfs_pkg::CH_LF) || (data_byte_i == cfs_pkg::CH_CR);

  // next state and results of the current byte
  always_comb begin
    bnd       = '0;
    phase_d   = phase_q;
    swallow_d = 1'b0;
    begin_f   = 1'b0;

    case (phase_q)
      cfs_pkg::PH_FIELD_START: begin
        begin_f = 1'b1;
      end
      cfs_pkg::PH_UNQUOTED: begin
        if (is_delim) begin
          bnd     = add_res(bnd, cfs_pkg::KIND_FIELD_END, 8'h00);
          phase_d = cfs_pkg::PH_FIELD_START;
        end else if (is_break) begin
          bnd       = add_res(bnd, cfs_pkg::KIND_FIELD_END, 8'h00);
          bnd       = add_res(bnd, cfs_pkg::KIND_ROW_END, 8'h00);
          phase_d   = cfs_pkg::PH_ROW_START;
          swallow_d = (data_byte_i == cfs_pkg::CH_CR);
        end else begin
          bnd = add_res(bnd, cfs_pkg::KIND_BYTE, data_byte_i);
        end
      end
      cfs_pkg::PH_QUOTED: begin
        if (is_quote) begin
          phase_d = cfs_pkg::PH_QUOTE_SEEN;
        end else begin
          bnd = add_res(bnd, cfs_pkg::KIND_BYTE, data_byte_i);
        end
      end
      cfs_pkg::PH_QUOTE_SEEN: begin
        if (is_quote) begin
          bnd     = add_res(bnd, cfs_pkg::KIND_BYTE, data_byte_i);
          phase_d = cfs_pkg::PH_QUOTED;
        end else begin
          bnd = add_res(bnd, cfs_pkg::KIND_FIELD_END, 8'h00);
          if (is_delim) begin
            phase_d = cfs_pkg::PH_FIELD_START;
          end else if (is_break) begin
            bnd       = add_res(bnd, cfs_pkg::KIND_ROW_END, 8'h00);
            phase_d   = cfs_pkg::PH_ROW_START;
            swallow_d = (data_byte_i == cfs_pkg::CH_CR);
          end else begin
            // stray byte after a closing quote ends the row and opens a new one
            bnd     = add_res(bnd, cfs_pkg::KIND_ROW_END, 8'h00);
            begin_f = 1'b1;
          end
        end
      end
      default: begin
        phase_d = cfs_pkg::PH_ROW_START;
        if (!(swallow_q && data_byte_i == cfs_pkg::CH_LF)) begin
          begin_f = 1'b1;
        end
      end
    endcase

    // first byte of a field
    if (begin_f) begin
      if (is_quote) begin
        phase_d = cfs_pkg::PH_QUOTED;
      end else if (is_delim) begin
        bnd     = add_res(bnd, cfs_pkg::KIND_FIELD_END, 8'h00);
        phase_d = cfs_pkg::PH_FIELD_START;
      end else if (is_break) begin
        bnd       = add_res(bnd, cfs_pkg::KIND_FIELD_END, 8'h00);
        bnd       = add_res(bnd, cfs_pkg::KIND_ROW_END, 8'h00);
        phase_d   = cfs_pkg::PH_ROW_START;
        swallow_d = (data_byte_i == cfs_pkg::CH_CR);
      end else begin
        bnd     = add_res(bnd, cfs_pkg::KIND_BYTE, data_byte_i);
        phase_d = cfs_pkg::PH_UNQUOTED;
      end
    end

    // close open field and row at end of stream
    if (end_of_stream_i) begin
      case (phase_d)
        cfs_pkg::PH_FIELD_START: begin
          bnd = add_res(bnd, cfs_pkg::KIND_ROW_END, 8'h00);
        end
        cfs_pkg::PH_UNQUOTED, cfs_pkg::PH_QUOTED, cfs_pkg::PH_QUOTE_SEEN: begin
          bnd = add_res(bnd, cfs_pkg::KIND_FIELD_END, 8'h00);
          bnd = add_res(bnd, cfs_pkg::KIND_ROW_END, 8'h00);
        end
        default: begin
        end
      endcase
      phase_d   = cfs_pkg::PH_ROW_START;
      swallow_d = 1'b0;
    end

    // mark the final result of this byte
    if (bnd.cnt != '0) begin
      bnd.res[bnd.cnt - cfs_pkg::CNT_W'(1)].last = 1'b1;
    end
  end

  assign push_o      = accept && (bnd.cnt != '0);
  assign push_data_o = bnd;

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= cfs_pkg::PH_ROW_START;
      swallow_q <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      swallow_q <= swallow_d;
    end
  end

endmodule

// File: sv/cfs_fifo.sv
// result bundle queue between front and back of the csv field splitter
// depends on cfs_pkg; register-based, depth set by a parameter
module cfs_fifo #(
  parameter int unsigned DEPTH = cfs_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cfs_pkg::bundle_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output cfs_pkg::bundle_t pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cfs_pkg::bundle_t   mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/cfs_back.sv
// back of the csv field splitter: hands out one result of a bundle per cycle while the receiver is ready
// depends on cfs_pkg; pulls bundles from cfs_fifo
module cfs_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  cfs_pkg::bundle_t q_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       content_o,
  output logic             last_of_run_o
);

  localparam int unsigned IDX_W = $clog2(cfs_pkg::MAX_RES);

  cfs_pkg::bundle_t cur_q, cur_d;
  logic             cur_valid_q, cur_valid_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  cfs_pkg::res_t    res;
  logic             out_fire, take;

  assign res           = cur_q.res[idx_q];
  assign out_valid_o   = cur_valid_q;
  assign kind_o        = res.kind;
  assign content_o     = res.content;
  assign last_of_run_o = res.last;
  assign out_fire      = cur_valid_q && out_ready_i;

  // load a new bundle when idle or when its final result leaves
  assign take  = !cur_valid_q || (out_fire && res.last);
  assign pop_o = take && q_valid_i;

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (take) begin
      cur_d       = q_data_i;
      cur_valid_d = q_valid_i;
      idx_d       = '0;
    end else if (out_fire) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

  // bundle payload, no reset
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

// File: sv/csv_field_splitter.sv
// csv field splitter: takes one text byte per input transaction, gives field bytes,
// field-end and row-end marks; an input byte is accepted every cycle while the bundle
// queue has room, and the back hands out one result per cycle while the receiver is
// ready, so a byte that causes more than one result (at most five) holds the output
// port until all of them leave; the sustained rate is one byte per cycle for ordinary
// field text; the queue (FIFO_DEPTH bundles, default four) absorbs bursts of marks.
// Registers: delimiter at byte address 0, quote character at 4, written over apb.
// depends on cfs_pkg, csv_in_if, csv_out_if, cfs_front, cfs_fifo, cfs_back
module csv_field_splitter #(
  parameter int unsigned FIFO_DEPTH = cfs_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cfs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cfs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cfs_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  csv_in_if.sink                         in_ch,
  csv_out_if.source                      out_ch
);

  logic [7:0]       delimiter_q, quote_char_q;
  logic             cfg_write;
  logic             q_full, push, q_valid, pop;
  cfs_pkg::bundle_t push_data, q_data;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delimiter_q  <= cfs_pkg::DELIMITER_RESET;
      quote_char_q <= cfs_pkg::QUOTE_CHAR_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        cfs_pkg::REG_DELIMITER:  delimiter_q  <= pwdata[7:0];
        cfs_pkg::REG_QUOTE_CHAR: quote_char_q <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[2])
      cfs_pkg::REG_DELIMITER:  prdata = {(cfs_pkg::APB_DATA_W - 8)'(0), delimiter_q};
      cfs_pkg::REG_QUOTE_CHAR: prdata = {(cfs_pkg::APB_DATA_W - 8)'(0), quote_char_q};
      default:                 prdata = '0;
    endcase
  end

  cfs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .delimiter_i     (delimiter_q),
    .quote_char_i    (quote_char_q),
    .in_valid_i      (in_ch.valid),
    .in_ready_o      (in_ch.ready),
    .data_byte_i     (in_ch.data_byte),
    .end_of_stream_i (in_ch.end_of_stream),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  cfs_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  cfs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .pop_o         (pop),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .kind_o        (out_ch.kind),
    .content_o     (out_ch.content),
    .last_of_run_o (out_ch.last_of_run)
  );

endmodule

// File: sv/cfs_checker.sv
// port-level checks of the csv field splitter, bound to the top level
// depends on cfs_pkg and csv_field_splitter_assert.svh
`include "csv_field_splitter_assert.svh"

module cfs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] kind_i,
  input logic [7:0] content_i,
  input logic       last_of_run_i
);

  // marks carry no content byte
  `CFS_ASSERT_NOW(a_mark_no_content, clk_i, rst_ni,
    out_valid_i && (kind_i != cfs_pkg::KIND_BYTE), content_i == 8'h00,
    "field or row end with nonzero content")

  // only the three known kinds leave the block
  `CFS_ASSERT_NOW(a_kind_legal, clk_i, rst_ni, out_valid_i,
    (kind_i == cfs_pkg::KIND_BYTE) || (kind_i == cfs_pkg::KIND_FIELD_END) ||
    (kind_i == cfs_pkg::KIND_ROW_END), "unknown result kind")

  // a result that is not taken stays on the port unchanged
  `CFS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(kind_i) && $stable(content_i) && $stable(last_of_run_i),
    "stalled result changed")

endmodule

bind csv_field_splitter cfs_checker u_cfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .kind_i        (out_ch.kind),
  .content_i     (out_ch.content),
  .last_of_run_i (out_ch.last_of_run)
);

// File: verif/tb_csv_field_splitter.sv
// self-checking testbench of csv_field_splitter: directed and random text streams
// under several delimiter and quote settings, checked against a mark predictor
// depends on cfs_pkg, csv_in_if, csv_out_if and the csv_field_splitter rtl
module tb_csv_field_splitter;

  // cycles to let a byte that gives no mark clear the pipeline
  localparam int unsigned SETTLE_CYCLES = 8;
  // long receiver hold-off and watchdog limit, in cycles
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  // predicts the marks each byte causes and checks the ones that come out
  class field_mark_scoreboard;
    logic [7:0]       delim;
    logic [7:0]       quote;
    cfs_pkg::phase_e  phase;
    bit               swallow_lf;
    cfs_pkg::res_t    step_marks[$];
    cfs_pkg::res_t    expected_marks[$];
    int unsigned      error_count;

    function new();
      delim       = cfs_pkg::DELIMITER_RESET;
      quote       = cfs_pkg::QUOTE_CHAR_RESET;
      phase       = cfs_pkg::PH_ROW_START;
      swallow_lf  = 1'b0;
      error_count = 0;
    endfunction

    function void set_reg(cfs_pkg::reg_e idx, logic [31:0] value);
      if (idx == cfs_pkg::REG_DELIMITER) begin
        delim = value[7:0];
      end else if (idx == cfs_pkg::REG_QUOTE_CHAR) begin
        quote = value[7:0];
      end
    endfunction

    function void add_mark(cfs_pkg::kind_e k, logic [7:0] b);
      cfs_pkg::res_t r;
      r.last    = 1'b0;
      r.kind    = k;
      r.content = (k == cfs_pkg::KIND_BYTE) ? b : 8'h00;
      step_marks.push_back(r);
    endfunction

    function void close_row(logic [7:0] b);
      add_mark(cfs_pkg::KIND_ROW_END, 8'h00);
      phase      = cfs_pkg::PH_ROW_START;
      swallow_lf = (b == cfs_pkg::CH_CR);
    endfunction

    // first byte of a field: quote first, then delimiter, then line break
    function void open_field(logic [7:0] b);
      if (b == quote) begin
        phase = cfs_pkg::PH_QUOTED;
      end else if (b == delim) begin
        add_mark(cfs_pkg::KIND_FIELD_END, 8'h00);
        phase = cfs_pkg::PH_FIELD_START;
      end else if (b == cfs_pkg::CH_LF || b == cfs_pkg::CH_CR) begin
        add_mark(cfs_pkg::KIND_FIELD_END, 8'h00);
        close_row(b);
      end else begin
        add_mark(cfs_pkg::KIND_BYTE, b);
        phase = cfs_pkg::PH_UNQUOTED;
      end
    endfunction

    // one accepted text byte: work out its marks and queue them
    function void note_byte(logic [7:0] b, logic eos);
      bit            was_swallow;
      cfs_pkg::res_t r;
      was_swallow = swallow_lf;
      swallow_lf  = 1'b0;
      step_marks.delete();
      case (phase)
        cfs_pkg::PH_FIELD_START: open_field(b);
        cfs_pkg::PH_UNQUOTED: begin
          if (b == delim) begin
            add_mark(cfs_pkg::KIND_FIELD_END, 8'h00);
            phase = cfs_pkg::PH_FIELD_START;
          end else if (b == cfs_pkg::CH_LF || b == cfs_pkg::CH_CR) begin
            add_mark(cfs_pkg::KIND_FIELD_END, 8'h00);
            close_row(b);
          end else begin
            add_mark(cfs_pkg::KIND_BYTE, b);
          end
        end
        cfs_pkg::PH_QUOTED: begin
          if (b == quote) begin
            phase = cfs_pkg::PH_QUOTE_SEEN;
          end else begin
            add_mark(cfs_pkg::KIND_BYTE, b);
          end
        end
        cfs_pkg::PH_QUOTE_SEEN: begin
          if (b == quote) begin
            add_mark(cfs_pkg::KIND_BYTE, b);
            phase = cfs_pkg::PH_QUOTED;
          end else begin
            add_mark(cfs_pkg::KIND_FIELD_END, 8'h00);
            if (b == delim) begin
              phase = cfs_pkg::PH_FIELD_START;
            end else if (b == cfs_pkg::CH_LF || b == cfs_pkg::CH_CR) begin
              close_row(b);
            end else begin
              // stray byte after a closing quote starts a new row
              add_mark(cfs_pkg::KIND_ROW_END, 8'h00);
              phase = cfs_pkg::PH_ROW_START;
              open_field(b);
            end
          end
        end
        default: begin
          phase = cfs_pkg::PH_ROW_START;
          if (!(was_swallow && b == cfs_pkg::CH_LF)) begin
            open_field(b);
          end
        end
      endcase
      // end of stream closes an open field and row
      if (eos) begin
        case (phase)
          cfs_pkg::PH_FIELD_START: add_mark(cfs_pkg::KIND_ROW_END, 8'h00);
          cfs_pkg::PH_UNQUOTED, cfs_pkg::PH_QUOTED, cfs_pkg::PH_QUOTE_SEEN: begin
            add_mark(cfs_pkg::KIND_FIELD_END, 8'h00);
            add_mark(cfs_pkg::KIND_ROW_END, 8'h00);
          end
          default: ;
        endcase
        phase      = cfs_pkg::PH_ROW_START;
        swallow_lf = 1'b0;
      end
      if (step_marks.size() > 0) begin
        r      = step_marks.pop_back();
        r.last = 1'b1;
        step_marks.push_back(r);
      end
      foreach (step_marks[i]) expected_marks.push_back(step_marks[i]);
    endfunction

    function void compare_field(string name, int unsigned exp_val, logic [7:0] act_val);
      if (act_val !== exp_val[7:0]) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
        error_count++;
      end
    endfunction

    // one accepted output transaction against the oldest expected mark
    function void check_mark(logic [1:0] kind, logic [7:0] content, logic last_of_run);
      cfs_pkg::res_t e;
      if (expected_marks.size() == 0) begin
        $display("%0t: unexpected mark, expected none, actual kind %0d content %0d last %0d",
                 $time, kind, content, last_of_run);
        error_count++;
      end else begin
        e = expected_marks.pop_front();
        compare_field("kind", e.kind, {6'd0, kind});
        compare_field("content", e.content, content);
        compare_field("last_of_run", e.last, {7'd0, last_of_run});
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [cfs_pkg::APB_ADDR_W-1:0] paddr;
  logic [cfs_pkg::APB_DATA_W-1:0] pwdata;
  logic [cfs_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  csv_in_if  in_ch();
  csv_out_if out_ch();

  field_mark_scoreboard sb;
  logic [7:0] text_q[$];

  bit src_idle_on;
  bit sink_idle_on;
  bit hold_off_req;
  int unsigned quiet_cycles = 0;

  csv_field_splitter u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver: random ready bursts, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (sink_idle_on && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_mark(out_ch.kind, out_ch.content, out_ch.last_of_run);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** csv_field_splitter: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // apb write: setup cycle, then access cycle until pready
  task apb_write(input cfs_pkg::reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= cfs_pkg::APB_ADDR_W'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // offer one byte until accepted, then maybe idle
  task send_byte(input logic [7:0] b, input logic eos);
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_stream <= eos;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_byte(b, eos);
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // stop offering and wait for every expected mark
  task drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_marks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // a byte that is neither delimiter, quote nor line break
  function logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == sb.delim || b == sb.quote || b == cfs_pkg::CH_LF ||
               b == cfs_pkg::CH_CR);
    return b;
  endfunction

  // well-formed record with random content
  task gen_record();
    int unsigned nf;
    int unsigned n;
    int unsigned sel;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) text_q.push_back(sb.delim);
      n = $urandom_range(0, 4);
      if ($urandom_range(0, 2) == 0) begin
        text_q.push_back(sb.quote);
        for (int i = 0; i < n; i++) begin
          sel = $urandom_range(0, 6);
          case (sel)
            0: text_q.push_back(sb.delim);
            1: text_q.push_back(cfs_pkg::CH_LF);
            2: text_q.push_back(cfs_pkg::CH_CR);
            3: begin
              text_q.push_back(sb.quote);
              text_q.push_back(sb.quote);
            end
            default: text_q.push_back(plain_byte());
          endcase
        end
        text_q.push_back(sb.quote);
      end else begin
        for (int i = 0; i < n; i++) text_q.push_back(plain_byte());
      end
    end
    sel = $urandom_range(0, 2);
    if (sel == 0) begin
      text_q.push_back(cfs_pkg::CH_LF);
    end else begin
      text_q.push_back(cfs_pkg::CH_CR);
      if (sel == 2) text_q.push_back(cfs_pkg::CH_LF);
    end
  endtask

  // noise: any byte, biased toward the special codes
  task gen_noise();
    int unsigned n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: text_q.push_back(sb.delim);
        1: text_q.push_back(sb.quote);
        2: text_q.push_back($urandom_range(0, 1) ? cfs_pkg::CH_LF : cfs_pkg::CH_CR);
        default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // one setting: write both registers while idle, then stream random text
  task run_setting(input logic [7:0] delim, input logic [7:0] quote,
                   input int unsigned count, input bit hold);
    logic eos;
    drain();
    apb_write(cfs_pkg::REG_DELIMITER, {24'd0, delim});
    apb_write(cfs_pkg::REG_QUOTE_CHAR, {24'd0, quote});
    text_q.delete();
    while (text_q.size() < count) begin
      if ($urandom_range(0, 6) == 0) begin
        gen_noise();
      end else begin
        gen_record();
      end
    end
    // long receiver hold-off while this setting streams
    hold_off_req = hold;
    foreach (text_q[i]) begin
      eos = (i == text_q.size() - 1) || ($urandom_range(0, 40) == 0);
      send_byte(text_q[i], eos);
    end
  endtask

  initial begin
    sb = new();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    hold_off_req = 1'b0;
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= 8'h00;
    in_ch.end_of_stream <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed text with reset settings
    send_byte(8'h00, 1'b0);
    send_byte(",", 1'b0);
    // quoted field with literal delimiter, line break and doubled quote
    send_byte("\"", 1'b0);
    send_byte(",", 1'b0);
    send_byte(cfs_pkg::CH_LF, 1'b0);
    send_byte("\"", 1'b0);
    send_byte("\"", 1'b0);
    send_byte("\"", 1'b0);
    // stray byte after closing quote
    send_byte("x", 1'b0);
    // cr lf pair, then an empty line
    send_byte(cfs_pkg::CH_CR, 1'b0);
    send_byte(cfs_pkg::CH_LF, 1'b0);
    send_byte(cfs_pkg::CH_LF, 1'b0);
    // lone cr followed by text
    send_byte(cfs_pkg::CH_CR, 1'b0);
    send_byte("y", 1'b0);
    send_byte(cfs_pkg::CH_LF, 1'b0);
    // trailing delimiter at end of stream
    send_byte(8'hFF, 1'b0);
    send_byte(",", 1'b1);
    // quote pending at end of stream
    send_byte("\"", 1'b0);
    send_byte("\"", 1'b1);
    // stream ending at a row boundary
    send_byte("a", 1'b0);
    send_byte(cfs_pkg::CH_LF, 1'b1);
    // closing quote, stray byte and end of stream together
    send_byte("\"", 1'b0);
    send_byte("\"", 1'b0);
    send_byte("q", 1'b1);
    // open unquoted field at end of stream
    send_byte("z", 1'b1);

    // random text; receiver holds off long in the first setting
    run_setting(cfs_pkg::DELIMITER_RESET, cfs_pkg::QUOTE_CHAR_RESET, 40, 1'b1);
    run_setting(";", "'", 25, 1'b0);
    run_setting(8'h00, 8'hFF, 25, 1'b0);
    run_setting(8'hFF, 8'h00, 20, 1'b0);
    // equal delimiter and quote codes
    run_setting(8'h22, 8'h22, 20, 1'b0);
    // delimiter equal to lf, quote equal to cr
    run_setting(cfs_pkg::CH_LF, cfs_pkg::CH_CR, 20, 1'b0);
    // last part without idling on either side
    drain();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    run_setting(cfs_pkg::DELIMITER_RESET, cfs_pkg::QUOTE_CHAR_RESET, 25, 1'b0);
    drain();

    if (sb.error_count == 0 && sb.expected_marks.size() == 0) begin
      $display("** csv_field_splitter: PASSED **");
    end else begin
      $display("** csv_field_splitter: FAILED **");
    end
    $finish;
  end

endmodule
